FILE: rtl/core/mps_pkg.sv
// Shared types, constants and helpers of the matrix power unit.
package mps_pkg;

   localparam int MAX_SIZE = 8;
   localparam int CELLS    = MAX_SIZE * MAX_SIZE;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CNT_W    = $clog2(CELLS + 1);
   localparam int IDX_W    = $clog2(MAX_SIZE);
   localparam int SIZE_W   = 4;
   localparam int EXP_W    = 32;
   localparam int DATA_W   = 64;
   localparam int HALF_W   = DATA_W / 2;
   localparam int CSR_W    = 32;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef logic [DATA_W-1:0]        word_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [SIZE_W-1:0]        size_type;
   typedef logic [EXP_W-1:0]         exp_type;
   typedef logic [CSR_W-1:0]         csr_data_type;

   typedef enum logic [0:0] {
      CSR_MATRIX_SIZE = 1'b0,
      CSR_EXPONENT    = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_ACC_MUL  = 1'b0,
      OP_BASE_SQR = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_TEST,
      ST_SHIFT,
      ST_MUL,
      ST_FLUSH,
      ST_COPY,
      ST_COPY_END,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic     load_we;
      addr_type load_addr;
      logic     init_we;
      addr_type init_addr;
      logic     init_one;
      logic     mul_vld;
      op_type   mul_op;
      addr_type a_addr;
      addr_type b_addr;
      addr_type dst_addr;
      logic     mul_first;
      logic     mul_last;
      logic     copy_vld;
      addr_type copy_addr;
      logic     copy_to_base;
      logic     drain_vld;
      addr_type drain_addr;
      logic     drain_last;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic drain_ok;
   } status_type;

   // linear position of (row, col) in an n x n row-major matrix
   function automatic addr_type addr_of(idx_type row, idx_type col, size_type n);
      logic [ADDR_W:0] lin;
      lin = (ADDR_W+1)'(row) * (ADDR_W+1)'(n) + (ADDR_W+1)'(col);
      return lin[ADDR_W-1:0];
   endfunction

endpackage

FILE: rtl/core/mps_if.sv
// Channel interfaces: element input, result output and register write.
interface mps_req_if;
   logic              valid;
   logic              ready;
   mps_pkg::elem_type element_value;
   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

interface mps_rsp_if;
   logic              valid;
   logic              ready;
   mps_pkg::elem_type result_value;
   logic              last_element;
   modport source (output valid, output result_value, output last_element, input ready);
   modport sink   (input valid, input result_value, input last_element, output ready);
endinterface

interface mps_csr_if;
   logic                  valid;
   logic                  ready;
   mps_pkg::csr_index_type index;
   mps_pkg::csr_data_type  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mps_ram.sv
// Generic RAM: one write port, two registered read ports.
module mps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

FILE: rtl/core/mps_ctrl.sv
// Sequencer: load count, exponent walk, loop counters and register file.
module mps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   mps_req_if.sink              req,
   mps_csr_if.sink              csr,
   output mps_pkg::cmd_type     cmd,
   input  mps_pkg::status_type  status
);
   import mps_pkg::*;

   state_type state_ff, state_in;
   size_type  size_ff;
   exp_type   exp_ff;
   exp_type   rem_ff, rem_in;
   cnt_type   cnt_ff, cnt_in;
   idx_type   row_ff, row_in, col_ff, col_in, k_ff, k_in;
   op_type    op_ff, op_in;

   size_type  n;
   size_type  nm1;
   cnt_type   total;
   cnt_type   cnt_inc;
   logic      row_end, col_end, k_end;

   always_comb begin
      if (size_ff == '0) begin
         n = size_type'(1);
      end else if (size_ff > size_type'(MAX_SIZE)) begin
         n = size_type'(MAX_SIZE);
      end else begin
         n = size_ff;
      end
   end

   assign nm1     = n - size_type'(1);
   assign total   = cnt_type'(n) * cnt_type'(n);
   assign cnt_inc = cnt_ff + cnt_type'(1);
   assign row_end = (size_type'(row_ff) == nm1);
   assign col_end = (size_type'(col_ff) == nm1);
   assign k_end   = (size_type'(k_ff) == nm1);
   assign csr.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= size_type'(MAX_SIZE);
         exp_ff  <= exp_type'(1);
      end else if (csr.valid) begin
         case (csr.index)
            CSR_MATRIX_SIZE: size_ff <= csr.data[SIZE_W-1:0];
            CSR_EXPONENT:    exp_ff  <= csr.data[EXP_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         rem_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         k_ff     <= '0;
         op_ff    <= OP_ACC_MUL;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         k_ff     <= k_in;
         op_ff    <= op_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      k_in      = k_ff;
      op_in     = op_ff;
      cmd       = '0;
      req.ready = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd.load_we   = 1'b1;
               cmd.load_addr = cnt_ff[ADDR_W-1:0];
               cnt_in        = cnt_inc;
               if (cnt_inc >= total) begin
                  cnt_in   = '0;
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            // accumulator := identity
            cmd.init_we   = 1'b1;
            cmd.init_addr = addr_of(row_ff, col_ff, n);
            cmd.init_one  = (row_ff == col_ff);
            col_in        = col_ff + idx_type'(1);
            if (col_end) begin
               col_in = '0;
               row_in = row_ff + idx_type'(1);
               if (row_end) begin
                  row_in   = '0;
                  rem_in   = exp_ff;
                  state_in = ST_TEST;
               end
            end
         end
         ST_TEST: begin
            if (rem_ff == '0) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else if (rem_ff[0]) begin
               op_in    = OP_ACC_MUL;
               row_in   = '0;
               col_in   = '0;
               k_in     = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            rem_in = rem_ff >> 1;
            if (rem_ff[EXP_W-1:1] != '0) begin
               op_in    = OP_BASE_SQR;
               row_in   = '0;
               col_in   = '0;
               k_in     = '0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_TEST;
            end
         end
         ST_MUL: begin
            cmd.mul_vld   = 1'b1;
            cmd.mul_op    = op_ff;
            cmd.a_addr    = addr_of(row_ff, k_ff, n);
            cmd.b_addr    = addr_of(k_ff, col_ff, n);
            cmd.dst_addr  = addr_of(row_ff, col_ff, n);
            cmd.mul_first = (k_ff == '0);
            cmd.mul_last  = k_end;
            k_in          = k_ff + idx_type'(1);
            if (k_end) begin
               k_in   = '0;
               col_in = col_ff + idx_type'(1);
               if (col_end) begin
                  col_in = '0;
                  row_in = row_ff + idx_type'(1);
                  if (row_end) begin
                     row_in   = '0;
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!status.busy) begin
               cnt_in   = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            cmd.copy_vld     = 1'b1;
            cmd.copy_addr    = cnt_ff[ADDR_W-1:0];
            cmd.copy_to_base = (op_ff == OP_BASE_SQR);
            cnt_in           = cnt_inc;
            if (cnt_inc == total) begin
               cnt_in   = '0;
               state_in = ST_COPY_END;
            end
         end
         ST_COPY_END: begin
            // last copy write lands this cycle
            state_in = (op_ff == OP_ACC_MUL) ? ST_SHIFT : ST_TEST;
         end
         ST_DRAIN: begin
            if (status.drain_ok) begin
               cmd.drain_vld  = 1'b1;
               cmd.drain_addr = cnt_ff[ADDR_W-1:0];
               cmd.drain_last = (cnt_inc == total);
               cnt_in         = cnt_inc;
               if (cnt_inc == total) begin
                  cnt_in   = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end
endmodule

FILE: rtl/core/mps_dp.sv
// Datapath: matrix stores, multiply-accumulate pipeline and result queue.
module mps_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mps_pkg::elem_type    load_data,
   input  mps_pkg::cmd_type     cmd,
   output mps_pkg::status_type  status,
   mps_rsp_if.source            rsp
);
   import mps_pkg::*;

   // store ports
   logic     base_we, acc_we, scr_we;
   addr_type base_waddr, acc_waddr;
   word_type base_wdata, acc_wdata;
   word_type base_rda, base_rdb, acc_rda, acc_rdb, scr_rd;

   // copy stage
   logic     cp_vld_ff, cp_base_ff;
   addr_type cp_addr_ff;

   // multiply pipeline
   logic     s1_vld_ff, s2_vld_ff, s3_vld_ff;
   op_type   s1_op_ff;
   logic     s1_first_ff, s2_first_ff, s3_first_ff;
   logic     s1_last_ff, s2_last_ff, s3_last_ff;
   addr_type s1_dst_ff, s2_dst_ff, s3_dst_ff;
   word_type a_val, b_val;
   word_type pp_ll_in, pp_ll_ff;
   logic [HALF_W-1:0] pp_lh_in, pp_lh_ff, pp_hl_in, pp_hl_ff;
   word_type prod_in, prod_ff, sum_in, sum_ff;

   // result queue
   logic       rd_vld_ff, rd_last_ff;
   word_type   q_val_ff [2];
   logic       q_last_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic       push, pop;

   assign base_we    = cmd.load_we | (cp_vld_ff & cp_base_ff);
   assign base_waddr = cmd.load_we ? cmd.load_addr : cp_addr_ff;
   assign base_wdata = cmd.load_we ? word_type'(load_data) : scr_rd;
   assign acc_we     = cmd.init_we | (cp_vld_ff & ~cp_base_ff);
   assign acc_waddr  = cmd.init_we ? cmd.init_addr : cp_addr_ff;
   assign acc_wdata  = cmd.init_we ? word_type'(cmd.init_one) : scr_rd;
   assign scr_we     = s3_vld_ff & s3_last_ff;

   mps_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_base (
      .clock(clock), .wr_en(base_we), .wr_addr(base_waddr), .wr_data(base_wdata),
      .rd_addr_a(cmd.a_addr), .rd_data_a(base_rda),
      .rd_addr_b(cmd.b_addr), .rd_data_b(base_rdb)
   );

   mps_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_acc (
      .clock(clock), .wr_en(acc_we), .wr_addr(acc_waddr), .wr_data(acc_wdata),
      .rd_addr_a(cmd.a_addr), .rd_data_a(acc_rda),
      .rd_addr_b(cmd.drain_addr), .rd_data_b(acc_rdb)
   );

   mps_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_scratch (
      .clock(clock), .wr_en(scr_we), .wr_addr(s3_dst_ff), .wr_data(sum_in),
      .rd_addr_a(cmd.copy_addr), .rd_data_a(scr_rd),
      .rd_addr_b(cmd.copy_addr), .rd_data_b()
   );

   // 64x64 wrapped product from three 32x32 partial products
   assign a_val    = (s1_op_ff == OP_BASE_SQR) ? base_rda : acc_rda;
   assign b_val    = base_rdb;
   assign pp_ll_in = word_type'(a_val[HALF_W-1:0]) * word_type'(b_val[HALF_W-1:0]);
   assign pp_lh_in = a_val[HALF_W-1:0] * b_val[DATA_W-1:HALF_W];
   assign pp_hl_in = a_val[DATA_W-1:HALF_W] * b_val[HALF_W-1:0];
   assign prod_in  = pp_ll_ff + {pp_lh_ff + pp_hl_ff, {HALF_W{1'b0}}};
   assign sum_in   = s3_first_ff ? prod_ff : (sum_ff + prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         cp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.mul_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         cp_vld_ff <= cmd.copy_vld;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= cmd.mul_op;
      s1_first_ff <= cmd.mul_first;
      s1_last_ff  <= cmd.mul_last;
      s1_dst_ff   <= cmd.dst_addr;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_dst_ff   <= s1_dst_ff;
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
      s3_dst_ff   <= s2_dst_ff;
      pp_ll_ff    <= pp_ll_in;
      pp_lh_ff    <= pp_lh_in;
      pp_hl_ff    <= pp_hl_in;
      prod_ff     <= prod_in;
      if (s3_vld_ff) begin
         sum_ff <= sum_in;
      end
      cp_base_ff  <= cmd.copy_to_base;
      cp_addr_ff  <= cmd.copy_addr;
      rd_last_ff  <= cmd.drain_last;
   end

   assign status.busy = s1_vld_ff | s2_vld_ff | s3_vld_ff;

   // two-entry result queue; a read is issued only when it will have room
   assign push     = rd_vld_ff;
   assign pop      = rsp.valid & rsp.ready;
   assign q_cnt_in = q_cnt_ff + 2'(push) - 2'(pop);
   assign status.drain_ok = (3'(q_cnt_ff) + 3'(rd_vld_ff)) < (3'd2 + 3'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         wp_ff     <= 1'b0;
         rp_ff     <= 1'b0;
         q_cnt_ff  <= '0;
      end else begin
         rd_vld_ff <= cmd.drain_vld;
         q_cnt_ff  <= q_cnt_in;
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_val_ff[wp_ff]  <= acc_rdb;
         q_last_ff[wp_ff] <= rd_last_ff;
      end
   end

   assign rsp.valid        = (q_cnt_ff != '0);
   assign rsp.result_value = elem_type'(q_val_ff[rp_ff]);
   assign rsp.last_element = q_last_ff[rp_ff];
endmodule

FILE: rtl/core/matrix_power_by_squaring_unit.sv
// Top level of the matrix power unit: sequencer plus datapath.
//
// Usage: write matrix_size (index 0, 1..8; 0 reads as 1, larger as 8) and
// exponent (index 1) on csr while idle; csr is always ready. Then send the
// n*n elements of the base matrix row-major on req, one transaction per
// cycle. The transaction carrying the last element starts the computation
// and req drops ready until every result read has been issued.
// Computation: the identity is set up first; then for each matrix product
// the terms are issued, the pipeline is flushed and the scratch store is
// copied back. One product per set exponent bit plus one squaring per bit
// below the top one: up to 63 products for a 32-bit exponent.
// The rate is set by the single 64x64 multiply-accumulate pipeline
// (three 32x32 partial products), fed one term per cycle from the base
// store and, for accumulator products, the accumulator store.
// Results come out on rsp row-major, one transaction per cycle when rsp is
// ready, with last_element on the final one. A two-entry queue holds the
// results; a stalled receiver pauses the reads from the accumulator store.
// Reset (synchronous) restores size 8 and exponent 1 and empties the load
// count and the queue; the stores need no clearing.
module matrix_power_by_squaring_unit (
   input  logic    clock,
   input  logic    reset,
   mps_req_if.sink   req,
   mps_rsp_if.source rsp,
   mps_csr_if.sink   csr
);
   import mps_pkg::*;

   cmd_type    cmd;
   status_type status;

   mps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .csr    (csr),
      .cmd    (cmd),
      .status (status)
   );

   mps_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .load_data (req.element_value),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp)
   );
endmodule

FILE: tb/mps_checker.sv
// Scoreboard of the matrix power unit: predicts result matrices and checks rsp.
module mps_checker
   import mps_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mps_req_if   req,
   mps_rsp_if   rsp,
   mps_csr_if   csr,
   output int   fail_count,
   output int   pending
);

   typedef word_type grid_type [CELLS];

   typedef struct packed {
      word_type value;
      logic     last;
   } cell_out_type;

   cell_out_type power_q[$];
   grid_type     base_grid;
   int           loaded;
   size_type     size_reg;
   exp_type      exp_reg;
   int           fails;

   initial begin
      fails      = 0;
      fail_count = 0;
      pending    = 0;
      loaded     = 0;
      size_reg   = SIZE_W'(MAX_SIZE);
      exp_reg    = 1;
   end

   function automatic int dim_of(size_type s);
      if (s == 0) return 1;
      if (s > MAX_SIZE) return MAX_SIZE;
      return int'(s);
   endfunction

   function automatic grid_type mat_product(grid_type a, grid_type b, int n);
      grid_type p;
      word_type sum;
      p = '{default: '0};
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            sum = '0;
            for (int k = 0; k < n; k++) sum += a[r*n+k] * b[k*n+c];
            p[r*n+c] = sum;
         end
      end
      return p;
   endfunction

   // binary exponentiation, lowest exponent bit first
   function automatic grid_type mat_power(grid_type b, exp_type e, int n);
      grid_type acc;
      acc = '{default: '0};
      for (int i = 0; i < n; i++) acc[i*n+i] = 1;
      while (e != 0) begin
         if (e[0]) acc = mat_product(acc, b, n);
         e = e >> 1;
         if (e != 0) b = mat_product(b, b, n);
      end
      return acc;
   endfunction

   always @(posedge clock) begin
      grid_type     res;
      int           n;
      cell_out_type want;
      if (reset) begin
         loaded   = 0;
         size_reg = SIZE_W'(MAX_SIZE);
         exp_reg  = 1;
         power_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               CSR_MATRIX_SIZE: size_reg = csr.data[SIZE_W-1:0];
               CSR_EXPONENT:    exp_reg  = csr.data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (power_q.size() == 0) begin
               $display("%0t: unexpected result %h last %b", $time,
                        rsp.result_value, rsp.last_element);
               fails++;
            end else begin
               want = power_q.pop_front();
               if (rsp.result_value !== want.value || rsp.last_element !== want.last) begin
                  $display("%0t: expected %h last %b, got %h last %b", $time,
                           want.value, want.last, rsp.result_value, rsp.last_element);
                  fails++;
               end
            end
         end
         if (req.valid && req.ready) begin
            if (loaded < CELLS) base_grid[loaded] = req.element_value;
            loaded = (loaded + 1) & 127;
            n = dim_of(size_reg);
            if (loaded >= n*n) begin
               res = mat_power(base_grid, exp_reg, n);
               for (int i = 0; i < n*n; i++) power_q.push_back({res[i], i == n*n-1});
               loaded = 0;
            end
         end
      end
      pending    <= power_q.size();
      fail_count <= fails;
   end

endmodule

FILE: tb/matrix_power_by_squaring_unit_tb.sv
// Testbench top of the matrix power unit: stimulus, stall patterns and verdict.
module matrix_power_by_squaring_unit_tb;
   import mps_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;

   // idling percentages of the current phase
   int   send_idle_pct;
   int   recv_stall_pct;
   logic hold_req;
   int   items_sent;

   mps_req_if req ();
   mps_rsp_if rsp ();
   mps_csr_if csr ();

   matrix_power_by_squaring_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   mps_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr        (csr),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // hard stop, well past the slowest legal run
   initial begin
      #40000000;
      $display("matrix_power_by_squaring_unit: mismatch");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      int hold_left;
      if (reset) begin
         hold_left = 0;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (hold_req) begin
         hold_left = 400;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic write_csr(csr_index_type idx, csr_data_type value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   // one element transaction; valid stays high unless the next one idles
   task automatic send_element(elem_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.element_value <= v;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic req_quiet();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every expected result, then let the block settle
   task automatic drain_all();
      int guard;
      guard = 0;
      while (pending != 0 && guard < 300000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
   endtask

   function automatic elem_type pick_element();
      case ($urandom_range(9))
         0: return 64'sh8000_0000_0000_0000;
         1: return 64'sh7fff_ffff_ffff_ffff;
         2: return -1;
         3: return 0;
         4, 5: return elem_type'($signed($urandom_range(0, 20)) - 10);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // mostly small matrices; out-of-range size codes now and then
   function automatic int pick_size();
      case ($urandom_range(19))
         0: return 0;
         1: return $urandom_range(9, 15);
         2, 3: return $urandom_range(5, 8);
         default: return $urandom_range(1, 4);
      endcase
   endfunction

   function automatic int eff_size(int s);
      if (s == 0) return 1;
      if (s > MAX_SIZE) return MAX_SIZE;
      return s;
   endfunction

   task automatic send_matrix(int n);
      for (int i = 0; i < n*n; i++) send_element(pick_element());
   endtask

   initial begin
      int s;
      int phase_no;
      exp_type e;
      reset          = 1'b1;
      hold_req       = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      req.valid         = 1'b0;
      req.element_value = '0;
      csr.valid = 1'b0;
      csr.index = CSR_MATRIX_SIZE;
      csr.data  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero exponent gives the identity
      write_csr(CSR_MATRIX_SIZE, 1);
      write_csr(CSR_EXPONENT, 0);
      send_element(64'sh7fff_ffff_ffff_ffff);
      req_quiet();
      drain_all();

      // size code 0 reads as 1; top exponent bit alone
      write_csr(CSR_MATRIX_SIZE, 0);
      write_csr(CSR_EXPONENT, 32'h8000_0000);
      send_element(64'sh8000_0000_0000_0000);
      req_quiet();
      drain_all();

      // largest exponent on a 2x2 of extremes
      write_csr(CSR_MATRIX_SIZE, 2);
      write_csr(CSR_EXPONENT, 32'hffff_ffff);
      send_element(64'sh8000_0000_0000_0000);
      send_element(64'sh7fff_ffff_ffff_ffff);
      send_element(-1);
      send_element(3);
      req_quiet();
      drain_all();

      // 3x3 squared, mixed extremes
      write_csr(CSR_MATRIX_SIZE, 3);
      write_csr(CSR_EXPONENT, 2);
      send_element(0);
      send_element(1);
      send_element(-1);
      send_element(64'sh7fff_ffff_ffff_ffff);
      send_element(64'sh8000_0000_0000_0000);
      send_element(64'sh5555_5555_5555_5555);
      send_element(64'shaaaa_aaaa_aaaa_aaaa);
      send_element(2);
      send_element(-2);
      req_quiet();
      drain_all();

      // random phases, cycling through the idling patterns
      phase_no = 0;
      while (items_sent < 420) begin
         case (phase_no % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         s = pick_size();
         case ($urandom_range(9))
            0: e = 0;
            1: e = (eff_size(s) <= 4) ? exp_type'($urandom) : exp_type'($urandom_range(0, 255));
            default: e = $urandom_range(1, 20);
         endcase
         write_csr(CSR_MATRIX_SIZE, s);
         write_csr(CSR_EXPONENT, e);
         if (phase_no == 5) begin
            // long receiver hold-off while the sender keeps pushing small matrices
            s = 2;
            write_csr(CSR_MATRIX_SIZE, s);
            send_idle_pct = 0;
            hold_req <= 1'b1;
            @(posedge clock);
            hold_req <= 1'b0;
            repeat (4) send_matrix(s);
         end else begin
            repeat ($urandom_range(1, 3)) send_matrix(eff_size(s));
         end
         req_quiet();
         drain_all();
         phase_no++;
      end

      // the largest exponent once on the full 8x8
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_csr(CSR_MATRIX_SIZE, 8);
      write_csr(CSR_EXPONENT, 32'hffff_ffff);
      send_matrix(8);
      req_quiet();
      drain_all();

      if (fail_count == 0 && pending == 0) begin
         $display("matrix_power_by_squaring_unit: match");
      end else begin
         $display("matrix_power_by_squaring_unit: mismatch");
      end
      $finish;
   end

endmodule
